// ===== src/bhq_pkg.sv =====
// Shared types and constants for the binary min-heap queue.
package bhq_pkg;

    localparam int HEAP_DEPTH_DEF = 128;
    localparam int KEY_WIDTH_DEF  = 32;
    localparam int KEY_IO_W       = 32;
    localparam int COUNT_IO_W     = 8;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [1:0] STAT_PUSHED = 2'd0;
    localparam logic [1:0] STAT_POPPED = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    typedef struct packed {
        logic                       mode;
        logic signed [KEY_IO_W-1:0] key_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [KEY_IO_W-1:0] key_out;
        logic [COUNT_IO_W-1:0]      entry_count;
    } out_word_t;

endpackage

// ===== src/bhq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/bhq_engine.sv =====
// Heap sequencer: sift-up and sift-down over the heap RAM, one level per step.
module bhq_engine #(
    parameter int HEAP_DEPTH = bhq_pkg::HEAP_DEPTH_DEF,
    parameter int KEY_WIDTH  = bhq_pkg::KEY_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  bhq_pkg::in_word_t  req,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_ready,
    output bhq_pkg::out_word_t res
);
    import bhq_pkg::*;

    localparam int AW  = $clog2(HEAP_DEPTH);
    localparam int NW  = $clog2(HEAP_DEPTH + 1);
    localparam int CW  = AW + 2;
    localparam int KEW = (KEY_WIDTH > KEY_IO_W) ? KEY_WIDTH : KEY_IO_W;
    localparam int CEW = (NW > COUNT_IO_W) ? NW : COUNT_IO_W;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_UP_CMP   = 8'b0000_0010,
        ST_POP_LAST = 8'b0000_0100,
        ST_POP_MOV  = 8'b0000_1000,
        ST_DN_L     = 8'b0001_0000,
        ST_DN_R     = 8'b0010_0000,
        ST_WR_KEY   = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t                      state_reg, state_next;
    logic [NW-1:0]               count_reg, count_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic signed [KEY_WIDTH-1:0] key_reg, key_next;
    logic signed [KEY_WIDTH-1:0] root_reg, root_next;
    logic signed [KEY_WIDTH-1:0] lval_reg, lval_next;
    logic [1:0]                  status_reg, status_next;

    logic                        we;
    logic [AW-1:0]               waddr;
    logic signed [KEY_WIDTH-1:0] wdata;
    logic [AW-1:0]               raddr;
    logic signed [KEY_WIDTH-1:0] rdata;

    logic signed [KEW-1:0]       key_in_ext;
    logic signed [KEW-1:0]       key_out_ext;
    logic [CEW-1:0]              count_ext;
    logic [AW-1:0]               parent_idx;
    logic [CW-1:0]               lchild;
    logic [CW-1:0]               rchild;
    logic [CW-1:0]               count_w;
    logic                        left_smaller;
    logic                        right_best;
    logic signed [KEY_WIDTH-1:0] cand_val;
    logic [AW-1:0]               best_idx;
    logic [CW-1:0]               best_lchild;

    bhq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign key_in_ext  = KEW'(req.key_in);
    assign parent_idx  = AW'(pos_reg - 1'b1) >> 1;
    assign lchild      = CW'({pos_reg, 1'b1});
    assign rchild      = lchild + CW'(1);
    assign count_w     = CW'(count_reg);

    // sift-down pick: left wins a tie between the children
    assign left_smaller = lval_reg < key_reg;
    assign cand_val     = left_smaller ? lval_reg : key_reg;
    assign right_best   = (rchild < count_w) && (rdata < cand_val);
    assign best_idx     = right_best ? rchild[AW-1:0] : lchild[AW-1:0];
    assign best_lchild  = CW'({best_idx, 1'b1});

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        root_next   = root_reg;
        lval_next   = lval_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = key_reg;
        raddr       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.mode == MODE_PUSH)
                    begin
                        if (count_reg == NW'(HEAP_DEPTH))
                        begin
                            status_next = STAT_FULL;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            status_next = STAT_PUSHED;
                            key_next    = key_in_ext[KEY_WIDTH-1:0];
                            pos_next    = count_reg[AW-1:0];
                            count_next  = count_reg + 1'b1;
                            raddr       = AW'(count_reg - 1'b1) >> 1;
                            state_next  = (count_reg == '0) ? ST_WR_KEY : ST_UP_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            status_next = STAT_POPPED;
                            count_next  = count_reg - 1'b1;
                            raddr       = '0;
                            state_next  = ST_POP_LAST;
                        end
                    end
                end
            end

            ST_UP_CMP:
            begin
                we = 1'b1;
                if (rdata > key_reg)
                begin
                    // parent moves down into the hole
                    wdata    = rdata;
                    pos_next = parent_idx;
                    raddr    = AW'(parent_idx - 1'b1) >> 1;
                    if (parent_idx == '0)
                    begin
                        state_next = ST_WR_KEY;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_POP_LAST:
            begin
                root_next  = rdata;
                raddr      = count_reg[AW-1:0];
                state_next = ST_POP_MOV;
            end

            ST_POP_MOV:
            begin
                key_next = rdata;
                pos_next = '0;
                raddr    = AW'(1);
                if (count_reg <= NW'(1))
                begin
                    state_next = ST_WR_KEY;
                end
                else
                begin
                    state_next = ST_DN_L;
                end
            end

            ST_DN_L:
            begin
                lval_next  = rdata;
                raddr      = rchild[AW-1:0];
                state_next = ST_DN_R;
            end

            ST_DN_R:
            begin
                we = 1'b1;
                if (right_best || left_smaller)
                begin
                    wdata    = right_best ? rdata : lval_reg;
                    pos_next = best_idx;
                    raddr    = best_lchild[AW-1:0];
                    if (best_lchild < count_w)
                    begin
                        state_next = ST_DN_L;
                    end
                    else
                    begin
                        state_next = ST_WR_KEY;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_WR_KEY:
            begin
                we         = 1'b1;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        root_reg   <= root_next;
        lval_reg   <= lval_next;
        status_reg <= status_next;
    end

    assign key_out_ext = KEW'(root_reg);
    assign count_ext   = CEW'(count_reg);

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res.status      = status_reg;
        res.key_out     = (status_reg == STAT_POPPED) ? key_out_ext[KEY_IO_W-1:0] : '0;
        res.entry_count = count_ext[COUNT_IO_W-1:0];
    end

endmodule

// ===== src/binary_min_heap_queue_top.sv =====
// Binary min-heap priority queue: top level with request and response channels.
//
//   channel | signals                        | word
//   --------+--------------------------------+----------------------------
//   req     | req_valid, req_ready, req_word | mode, key_in
//   rsp     | rsp_valid, rsp_ready, rsp_word | status, key_out, entry_count
//
// One word at a time. Push climbs the key one level per step toward the root;
// pop moves the last entry to the root and sinks it one level per step, reading
// the left and then the right child through the heap RAM's single read port,
// whose read data is registered.
// Reset empties the heap at once; RAM contents are left as they are.
// A held response stalls only the completion of the next word, not its start.
module binary_min_heap_queue_top #(
    parameter int HEAP_DEPTH = bhq_pkg::HEAP_DEPTH_DEF,
    parameter int KEY_WIDTH  = bhq_pkg::KEY_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bhq_pkg::in_word_t  req_word,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output bhq_pkg::out_word_t rsp_word
);
    import bhq_pkg::*;

    logic      eng_idle;
    logic      eng_res_valid;
    logic      eng_res_ready;
    out_word_t eng_res;

    logic      rsp_valid_reg, rsp_valid_next;
    out_word_t rsp_word_reg, rsp_word_next;

    bhq_engine #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_valid & eng_idle),
        .req       (req_word),
        .idle      (eng_idle),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res)
    );

    assign req_ready     = eng_idle;
    assign eng_res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        if (eng_res_valid && eng_res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = eng_res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the binary min-heap queue top level.
`timescale 1ns / 100ps

module tb_top;
    import bhq_pkg::*;

    localparam int DEPTH       = HEAP_DEPTH_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int END_CYCLES  = 40;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    in_word_t   req_word = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    out_word_t  rsp_word;

    // words waiting to be offered, and answers waiting to arrive
    in_word_t   req_backlog [$];
    out_word_t  heap_answers [$];

    // shadow copy of the heap
    logic signed [KEY_IO_W-1:0] shadow_keys [DEPTH];
    int         shadow_fill = 0;

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         gen_fill = 0;
    int         errors = 0;
    int         words_out = 0;
    int         hold_left = 0;
    int         holds_done = 0;
    int         stall_cycles = 0;
    int         status_tally [4] = '{0, 0, 0, 0};

    binary_min_heap_queue_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    always #6 clk = ~clk;

    function automatic out_word_t heap_apply(in_word_t w);
        out_word_t r;
        int pos;
        int up;
        int best;
        int kid;
        logic signed [KEY_IO_W-1:0] tmp;
        r = '0;
        if (w.mode == MODE_PUSH) begin
            if (shadow_fill >= DEPTH) begin
                r.status = STAT_FULL;
            end
            else begin
                pos = shadow_fill;
                shadow_keys[pos] = w.key_in;
                shadow_fill++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (shadow_keys[up] <= shadow_keys[pos])
                        break;
                    tmp = shadow_keys[up];
                    shadow_keys[up] = shadow_keys[pos];
                    shadow_keys[pos] = tmp;
                    pos = up;
                end
                r.status = STAT_PUSHED;
            end
        end
        else if (shadow_fill == 0) begin
            r.status = STAT_EMPTY;
        end
        else begin
            r.key_out = shadow_keys[0];
            shadow_fill--;
            shadow_keys[0] = shadow_keys[shadow_fill];
            pos = 0;
            while (1) begin
                best = pos;
                kid = 2 * pos + 1;
                // left child wins a tie: right must be strictly smaller
                if (kid < shadow_fill && shadow_keys[kid] < shadow_keys[best])
                    best = kid;
                kid++;
                if (kid < shadow_fill && shadow_keys[kid] < shadow_keys[best])
                    best = kid;
                if (best == pos)
                    break;
                tmp = shadow_keys[best];
                shadow_keys[best] = shadow_keys[pos];
                shadow_keys[pos] = tmp;
                pos = best;
            end
            r.status = STAT_POPPED;
        end
        r.entry_count = COUNT_IO_W'(shadow_fill);
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // driver: predicts on acceptance, then offers the next word or idles
    always @(posedge clk) begin : driver
        out_word_t ans;
        if (!rst_n) begin
            req_valid <= 1'b0;
        end
        else begin
            if (req_valid && req_ready) begin
                ans = heap_apply(req_word);
                heap_answers.push_back(ans);
                status_tally[ans.status]++;
            end
            if (!req_valid || req_ready) begin
                if (req_backlog.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    req_valid <= 1'b1;
                    req_word  <= req_backlog.pop_front();
                end
                else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each response word, drives rsp_ready
    always @(posedge clk) begin : monitor
        out_word_t want;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                if (heap_answers.size() == 0) begin
                    $display("%0t: response with none pending: status %0d key %0d count %0d",
                             $time, rsp_word.status, rsp_word.key_out, rsp_word.entry_count);
                    errors++;
                end
                else begin
                    want = heap_answers.pop_front();
                    check_field("status", want.status, rsp_word.status);
                    check_field("key_out", longint'(want.key_out), longint'(rsp_word.key_out));
                    check_field("entry_count", want.entry_count, rsp_word.entry_count);
                end
                words_out++;
                // long hold-off so the request side backs up
                if (words_out == 300 || words_out == 900) begin
                    hold_left = HOLD_CYCLES;
                    holds_done++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else begin
                rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic add_push(logic signed [KEY_IO_W-1:0] key);
        in_word_t w;
        w.mode   = MODE_PUSH;
        w.key_in = key;
        req_backlog.push_back(w);
        if (gen_fill < DEPTH)
            gen_fill++;
    endtask

    task automatic add_pop();
        in_word_t w;
        w.mode   = MODE_POP;
        w.key_in = $urandom;    // ignored on pop, still toggled
        req_backlog.push_back(w);
        if (gen_fill > 0)
            gen_fill--;
    endtask

    function automatic logic signed [KEY_IO_W-1:0] pick_key();
        case ($urandom_range(4, 0))
            0, 1: return $urandom;
            2: return KEY_IO_W'(int'($urandom_range(8, 0)) - 4);    // many duplicates
            3: return 32'sh7fff_ffff - KEY_IO_W'($urandom_range(3, 0));
            default: return 32'sh8000_0000 + KEY_IO_W'($urandom_range(3, 0));
        endcase
    endfunction

    task automatic drain_wait();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || heap_answers.size() != 0);
    endtask

    task automatic run_phase(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        // fill past full, then drain past empty
        while (gen_fill < DEPTH)
            add_push(pick_key());
        repeat (3) add_push(pick_key());
        while (gen_fill > 0)
            add_pop();
        repeat (2) add_pop();
        // random mix, leaning toward pushes while the heap is shallow
        repeat (90) begin
            if ($urandom_range(99, 0) < (gen_fill < 8 ? 70 : 50))
                add_push(pick_key());
            else
                add_pop();
        end
        while (gen_fill > 0)
            add_pop();
        drain_wait();
    endtask

    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_pop();                    // pop on empty
        add_push(32'sd0);
        add_push(32'sh8000_0000);
        add_push(32'sh7fff_ffff);
        add_push(-32'sd1);
        add_push(32'sd1);
        add_push(32'sd5);
        add_push(32'sd5);
        add_push(32'sd5);             // equal keys
        add_push(32'sh8000_0000);
        add_push(32'sh7fff_ffff);
        repeat (10) add_pop();
        add_pop();
        add_push(32'sd3);
        add_pop();
        add_pop();
        drain_wait();

        run_phase(7, 75);
        run_phase(75, 7);
        run_phase(0, 0);

        repeat (END_CYCLES) @(posedge clk);
        if (heap_answers.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, heap_answers.size());
            errors++;
        end
        $display("Ran %0d words: %0d pushes, %0d pops, %0d pops on empty, %0d dropped at full.",
                 words_out, status_tally[STAT_PUSHED], status_tally[STAT_POPPED],
                 status_tally[STAT_EMPTY], status_tally[STAT_FULL]);
        $display("Idle mixes 7/75, 75/7, 0/0 percent; %0d response hold-offs of %0d cycles.",
                 holds_done, HOLD_CYCLES);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
